>>> rtl/rvex_pkg.sv
package rvex_pkg;

    typedef enum logic [3:0] {
        REQ_BRANCH = 4'd0,
        REQ_JAL    = 4'd1,
        REQ_JALR   = 4'd2,
        REQ_LUI    = 4'd3,
        REQ_AUIPC  = 4'd4,
        REQ_STORE  = 4'd5,
        REQ_LOAD   = 4'd6,
        REQ_OPIMM  = 4'd7,
        REQ_OP     = 4'd8,
        REQ_HALT   = 4'd9
    } t_req_type;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_LOAD  = 3'd2,
        ACT_STORE = 3'd3,
        ACT_HALT  = 3'd4
    } t_action;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'b000;
    localparam logic [2:0] F3_BNE  = 3'b001;
    localparam logic [2:0] F3_BLT  = 3'b100;
    localparam logic [2:0] F3_BGE  = 3'b101;
    localparam logic [2:0] F3_BLTU = 3'b110;
    localparam logic [2:0] F3_BGEU = 3'b111;

    // ALU funct3
    localparam logic [2:0] F3_ADD  = 3'b000;
    localparam logic [2:0] F3_SLL  = 3'b001;
    localparam logic [2:0] F3_SLT  = 3'b010;
    localparam logic [2:0] F3_SLTU = 3'b011;
    localparam logic [2:0] F3_XOR  = 3'b100;
    localparam logic [2:0] F3_SR   = 3'b101;
    localparam logic [2:0] F3_OR   = 3'b110;
    localparam logic [2:0] F3_AND  = 3'b111;

    // load/store funct3
    localparam logic [2:0] F3_MB   = 3'b000;
    localparam logic [2:0] F3_MH   = 3'b001;
    localparam logic [2:0] F3_MW   = 3'b010;
    localparam logic [2:0] F3_MBU  = 3'b100;
    localparam logic [2:0] F3_MHU  = 3'b101;

    localparam logic [4:0]  SHAMT_MASK = 5'b11111;
    localparam logic [31:0] LINK_STEP  = 32'd4;

    typedef struct packed {
        t_action     action;
        logic        redirect;
        logic [31:0] target_pc;
        logic [4:0]  write_reg;
        logic [31:0] write_value;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic        mem_signed;
        logic [31:0] store_data;
    } t_result;

endpackage

>>> rtl/rvex_alu.sv
module rvex_alu (
    input  logic [2:0]  i_funct3,
    input  logic        i_alt_bit,
    input  logic        i_allow_sub,
    input  logic [31:0] i_op_a,
    input  logic [31:0] i_op_b,
    output logic [31:0] o_result
);

    logic [4:0] shamt;

    assign shamt = i_op_b[4:0] & rvex_pkg::SHAMT_MASK;

    always_comb begin
        case (i_funct3)
            rvex_pkg::F3_ADD:  o_result = (i_allow_sub && i_alt_bit) ? i_op_a - i_op_b
                                                                     : i_op_a + i_op_b;
            rvex_pkg::F3_SLL:  o_result = i_op_a << shamt;
            rvex_pkg::F3_SLT:  o_result = {31'd0, $signed(i_op_a) < $signed(i_op_b)};
            rvex_pkg::F3_SLTU: o_result = {31'd0, i_op_a < i_op_b};
            rvex_pkg::F3_XOR:  o_result = i_op_a ^ i_op_b;
            rvex_pkg::F3_SR:   o_result = i_alt_bit ? 32'($signed(i_op_a) >>> shamt)
                                                    : i_op_a >> shamt;
            rvex_pkg::F3_OR:   o_result = i_op_a | i_op_b;
            rvex_pkg::F3_AND:  o_result = i_op_a & i_op_b;
            default:           o_result = '0;
        endcase
    end

endmodule

>>> rtl/rv32i_execute_unit.sv
// A request passes the input register and then the result register before its result is valid.
// Throughput: one request per cycle while the output does not stall; the single pass of decode,
// ALU and adders between the two registers sets that figure.
// Ready propagates backwards combinationally through both stages.
// Reset (synchronous, active low) empties both stages; payload registers are not reset.
module rv32i_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_req_type,
    input  logic [2:0]  i_funct3,
    input  logic        i_alt_bit,
    input  logic [31:0] i_src1_value,
    input  logic [31:0] i_src2_value,
    input  logic [31:0] i_immediate,
    input  logic [31:0] i_pc_value,
    input  logic [4:0]  i_dest_reg,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_action,
    output logic        o_redirect,
    output logic [31:0] o_target_pc,
    output logic [4:0]  o_write_reg,
    output logic [31:0] o_write_value,
    output logic [31:0] o_mem_address,
    output logic [1:0]  o_mem_size,
    output logic        o_mem_signed,
    output logic [31:0] o_store_data
);

    // input stage
    logic        r_s1_valid;
    logic [3:0]  r_type;
    logic [2:0]  r_f3;
    logic        r_alt;
    logic [31:0] r_rs1;
    logic [31:0] r_rs2;
    logic [31:0] r_imm;
    logic [31:0] r_pc;
    logic [4:0]  r_rd;

    // result stage
    logic              r_s2_valid;
    rvex_pkg::t_result r_res;
    rvex_pkg::t_result n_res;

    logic        s1_adv;
    logic        s2_free;
    logic [31:0] alu_b;
    logic [31:0] alu_out;
    logic        is_op;
    logic        taken;
    logic [31:0] pc_imm;
    logic [31:0] rs1_imm;
    logic [31:0] pc_link;

    assign s2_free    = !r_s2_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_ready = !r_s1_valid || s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_type <= i_req_type;
            r_f3   <= i_funct3;
            r_alt  <= i_alt_bit;
            r_rs1  <= i_src1_value;
            r_rs2  <= i_src2_value;
            r_imm  <= i_immediate;
            r_pc   <= i_pc_value;
            r_rd   <= i_dest_reg;
        end
    end

    assign is_op   = (r_type == rvex_pkg::REQ_OP);
    assign alu_b   = is_op ? r_rs2 : r_imm;
    assign pc_imm  = r_pc + r_imm;
    assign rs1_imm = r_rs1 + r_imm;
    assign pc_link = r_pc + rvex_pkg::LINK_STEP;

    rvex_alu u_alu (
        .i_funct3    (r_f3),
        .i_alt_bit   (r_alt),
        .i_allow_sub (is_op),
        .i_op_a      (r_rs1),
        .i_op_b      (alu_b),
        .o_result    (alu_out)
    );

    always_comb begin
        case (r_f3)
            rvex_pkg::F3_BEQ:  taken = (r_rs1 == r_rs2);
            rvex_pkg::F3_BNE:  taken = (r_rs1 != r_rs2);
            rvex_pkg::F3_BLT:  taken = ($signed(r_rs1) < $signed(r_rs2));
            rvex_pkg::F3_BGE:  taken = ($signed(r_rs1) >= $signed(r_rs2));
            rvex_pkg::F3_BLTU: taken = (r_rs1 < r_rs2);
            rvex_pkg::F3_BGEU: taken = (r_rs1 >= r_rs2);
            default:           taken = 1'b0;
        endcase
    end

    always_comb begin
        n_res = '0;
        case (r_type)
            rvex_pkg::REQ_BRANCH: begin
                if (taken) begin
                    n_res.redirect  = 1'b1;
                    n_res.target_pc = pc_imm;
                end
            end
            rvex_pkg::REQ_JAL, rvex_pkg::REQ_JALR: begin
                n_res.redirect    = 1'b1;
                n_res.target_pc   = (r_type == rvex_pkg::REQ_JAL) ? pc_imm
                                                                  : {rs1_imm[31:1], 1'b0};
                n_res.action      = rvex_pkg::ACT_WRITE;
                n_res.write_reg   = r_rd;
                n_res.write_value = pc_link;
            end
            rvex_pkg::REQ_LUI, rvex_pkg::REQ_AUIPC: begin
                n_res.action      = rvex_pkg::ACT_WRITE;
                n_res.write_reg   = r_rd;
                n_res.write_value = (r_type == rvex_pkg::REQ_LUI) ? r_imm : pc_imm;
            end
            rvex_pkg::REQ_STORE: begin
                if (r_f3 inside {rvex_pkg::F3_MB, rvex_pkg::F3_MH, rvex_pkg::F3_MW}) begin
                    n_res.action      = rvex_pkg::ACT_STORE;
                    n_res.mem_address = rs1_imm;
                    n_res.mem_size    = r_f3[1:0];
                    n_res.store_data  = r_rs2;
                end
            end
            rvex_pkg::REQ_LOAD: begin
                if (r_f3 inside {rvex_pkg::F3_MB, rvex_pkg::F3_MH, rvex_pkg::F3_MW,
                                 rvex_pkg::F3_MBU, rvex_pkg::F3_MHU}) begin
                    n_res.action      = rvex_pkg::ACT_LOAD;
                    n_res.write_reg   = r_rd;
                    n_res.mem_address = rs1_imm;
                    n_res.mem_size    = r_f3[1:0];
                    n_res.mem_signed  = !r_f3[2];
                end
            end
            rvex_pkg::REQ_OPIMM, rvex_pkg::REQ_OP: begin
                n_res.action      = rvex_pkg::ACT_WRITE;
                n_res.write_reg   = r_rd;
                n_res.write_value = alu_out;
            end
            rvex_pkg::REQ_HALT: begin
                n_res.action = rvex_pkg::ACT_HALT;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_s2_valid;
    assign o_action      = r_res.action;
    assign o_redirect    = r_res.redirect;
    assign o_target_pc   = r_res.target_pc;
    assign o_write_reg   = r_res.write_reg;
    assign o_write_value = r_res.write_value;
    assign o_mem_address = r_res.mem_address;
    assign o_mem_size    = r_res.mem_size;
    assign o_mem_signed  = r_res.mem_signed;
    assign o_store_data  = r_res.store_data;

    // a held input-stage request must not vanish while the result stage is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_free) |=> r_s1_valid)
        else $error("input stage request dropped while stalled");

    a_redirect_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_redirect) |-> (o_target_pc == 32'd0))
        else $error("target pc set without redirect");

    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == rvex_pkg::ACT_HALT) |->
        (!o_redirect && o_write_reg == 5'd0 && o_mem_address == 32'd0
         && o_store_data == 32'd0))
        else $error("halt result carries other fields");

    a_store_no_wreg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == rvex_pkg::ACT_STORE) |->
        (o_write_reg == 5'd0 && o_write_value == 32'd0 && !o_redirect))
        else $error("store result carries register write fields");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule

>>> tb/tb_rv32i_execute_unit.sv
module tb_rv32i_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_PCT     = 38;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 10;

    typedef struct {
        logic [3:0]  req_type;
        logic [2:0]  funct3;
        logic        alt_bit;
        logic [31:0] src1;
        logic [31:0] src2;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [4:0]  rd;
        logic        drain_first;   // hold this request back until all results are in
    } t_exec_req;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [3:0]  i_req_type   = '0;
    logic [2:0]  i_funct3     = '0;
    logic        i_alt_bit    = 1'b0;
    logic [31:0] i_src1_value = '0;
    logic [31:0] i_src2_value = '0;
    logic [31:0] i_immediate  = '0;
    logic [31:0] i_pc_value   = '0;
    logic [4:0]  i_dest_reg   = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [2:0]  o_action;
    logic        o_redirect;
    logic [31:0] o_target_pc;
    logic [4:0]  o_write_reg;
    logic [31:0] o_write_value;
    logic [31:0] o_mem_address;
    logic [1:0]  o_mem_size;
    logic        o_mem_signed;
    logic [31:0] o_store_data;

    t_exec_req         pending_reqs[$];
    rvex_pkg::t_result exec_results[$];
    t_exec_req         bus_req;
    int                n_accepted  = 0;
    int                n_errors    = 0;
    int                cycle_count = 0;

    rv32i_execute_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_funct3      (i_funct3),
        .i_alt_bit     (i_alt_bit),
        .i_src1_value  (i_src1_value),
        .i_src2_value  (i_src2_value),
        .i_immediate   (i_immediate),
        .i_pc_value    (i_pc_value),
        .i_dest_reg    (i_dest_reg),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_action      (o_action),
        .o_redirect    (o_redirect),
        .o_target_pc   (o_target_pc),
        .o_write_reg   (o_write_reg),
        .o_write_value (o_write_value),
        .o_mem_address (o_mem_address),
        .o_mem_size    (o_mem_size),
        .o_mem_signed  (o_mem_signed),
        .o_store_data  (o_store_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] alu_value(logic [2:0] f3, logic alt, logic [31:0] a,
                                              logic [31:0] b, logic allow_sub);
        logic [4:0]  sh;
        logic [31:0] v;
        sh = b[4:0] & rvex_pkg::SHAMT_MASK;
        case (f3)
            rvex_pkg::F3_ADD:  v = (allow_sub && alt) ? a - b : a + b;
            rvex_pkg::F3_SLL:  v = a << sh;
            rvex_pkg::F3_SLT:  v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            rvex_pkg::F3_SLTU: v = (a < b) ? 32'd1 : 32'd0;
            rvex_pkg::F3_XOR:  v = a ^ b;
            rvex_pkg::F3_SR:   v = alt ? $unsigned($signed(a) >>> sh) : a >> sh;
            rvex_pkg::F3_OR:   v = a | b;
            default:           v = a & b;
        endcase
        return v;
    endfunction

    function automatic rvex_pkg::t_result predict_exec(t_exec_req r);
        rvex_pkg::t_result res;
        logic              taken;
        res   = '0;
        taken = 1'b0;
        case (r.req_type)
            rvex_pkg::REQ_BRANCH: begin
                case (r.funct3)
                    rvex_pkg::F3_BEQ:  taken = r.src1 == r.src2;
                    rvex_pkg::F3_BNE:  taken = r.src1 != r.src2;
                    rvex_pkg::F3_BLT:  taken = $signed(r.src1) < $signed(r.src2);
                    rvex_pkg::F3_BGE:  taken = $signed(r.src1) >= $signed(r.src2);
                    rvex_pkg::F3_BLTU: taken = r.src1 < r.src2;
                    rvex_pkg::F3_BGEU: taken = r.src1 >= r.src2;
                    default:           taken = 1'b0;
                endcase
                if (taken) begin
                    res.redirect  = 1'b1;
                    res.target_pc = r.pc + r.imm;
                end
            end
            rvex_pkg::REQ_JAL, rvex_pkg::REQ_JALR: begin
                res.redirect    = 1'b1;
                res.target_pc   = (r.req_type == rvex_pkg::REQ_JAL) ? r.pc + r.imm
                                                                    : (r.src1 + r.imm) & ~32'd1;
                res.action      = rvex_pkg::ACT_WRITE;
                res.write_reg   = r.rd;
                res.write_value = r.pc + rvex_pkg::LINK_STEP;
            end
            rvex_pkg::REQ_LUI, rvex_pkg::REQ_AUIPC: begin
                res.action      = rvex_pkg::ACT_WRITE;
                res.write_reg   = r.rd;
                res.write_value = (r.req_type == rvex_pkg::REQ_LUI) ? r.imm : r.pc + r.imm;
            end
            rvex_pkg::REQ_STORE: begin
                if (r.funct3 == rvex_pkg::F3_MB || r.funct3 == rvex_pkg::F3_MH ||
                    r.funct3 == rvex_pkg::F3_MW) begin
                    res.action      = rvex_pkg::ACT_STORE;
                    res.mem_address = r.src1 + r.imm;
                    res.mem_size    = r.funct3[1:0];
                    res.store_data  = r.src2;
                end
            end
            rvex_pkg::REQ_LOAD: begin
                if (r.funct3 == rvex_pkg::F3_MB || r.funct3 == rvex_pkg::F3_MH ||
                    r.funct3 == rvex_pkg::F3_MW || r.funct3 == rvex_pkg::F3_MBU ||
                    r.funct3 == rvex_pkg::F3_MHU) begin
                    res.action      = rvex_pkg::ACT_LOAD;
                    res.write_reg   = r.rd;
                    res.mem_address = r.src1 + r.imm;
                    res.mem_size    = r.funct3[1:0];
                    res.mem_signed  = (r.funct3 == rvex_pkg::F3_MB ||
                                       r.funct3 == rvex_pkg::F3_MH ||
                                       r.funct3 == rvex_pkg::F3_MW);
                end
            end
            rvex_pkg::REQ_OPIMM: begin
                res.action      = rvex_pkg::ACT_WRITE;
                res.write_reg   = r.rd;
                res.write_value = alu_value(r.funct3, r.alt_bit, r.src1, r.imm, 1'b0);
            end
            rvex_pkg::REQ_OP: begin
                res.action      = rvex_pkg::ACT_WRITE;
                res.write_reg   = r.rd;
                res.write_value = alu_value(r.funct3, r.alt_bit, r.src1, r.src2, 1'b1);
            end
            rvex_pkg::REQ_HALT: res.action = rvex_pkg::ACT_HALT;
            default: ;
        endcase
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    task automatic add_req(logic [3:0] kind, logic [2:0] f3, logic alt, logic [31:0] s1,
                           logic [31:0] s2, logic [31:0] imm, logic [31:0] pc,
                           logic [4:0] rd, logic drain);
        t_exec_req r;
        r = '{kind, f3, alt, s1, s2, imm, pc, rd, drain};
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h8000_0000;
            3:       v = 32'h7FFF_FFFF;
            4:       v = $urandom_range(0, 64);
            5:       v = -$urandom_range(1, 64);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_imm();
        logic [31:0] b;
        b = $urandom;
        if ($urandom_range(0, 9) < 6)
            return {{20{b[11]}}, b[11:0]};
        return rand_operand();
    endfunction

    // quiet window: neither side idles
    function automatic logic idle_now();
        if (n_accepted >= 300 && n_accepted < 450)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // driver
    always @(posedge i_clk) begin : drv_proc
        logic      fire;
        logic      drive;
        t_exec_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                exec_results.push_back(predict_exec(bus_req));
                n_accepted++;
            end
            if (!i_in_valid || fire) begin
                drive = pending_reqs.size() > 0 && !idle_now();
                if (drive && pending_reqs[0].drain_first && exec_results.size() != 0)
                    drive = 1'b0;
                if (drive) begin
                    nxt          = pending_reqs.pop_front();
                    bus_req      = nxt;
                    i_req_type   <= nxt.req_type;
                    i_funct3     <= nxt.funct3;
                    i_alt_bit    <= nxt.alt_bit;
                    i_src1_value <= nxt.src1;
                    i_src2_value <= nxt.src2;
                    i_immediate  <= nxt.imm;
                    i_pc_value   <= nxt.pc;
                    i_dest_reg   <= nxt.rd;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon_proc
        rvex_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (exec_results.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got action %h",
                             $realtime, o_action);
                end else begin
                    want = exec_results.pop_front();
                    check_field("action", 32'(want.action), 32'(o_action));
                    check_field("redirect", 32'(want.redirect), 32'(o_redirect));
                    check_field("target_pc", want.target_pc, o_target_pc);
                    check_field("write_reg", 32'(want.write_reg), 32'(o_write_reg));
                    check_field("write_value", want.write_value, o_write_value);
                    check_field("mem_address", want.mem_address, o_mem_address);
                    check_field("mem_size", 32'(want.mem_size), 32'(o_mem_size));
                    check_field("mem_signed", 32'(want.mem_signed), 32'(o_mem_signed));
                    check_field("store_data", want.store_data, o_store_data);
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL rv32i_execute_unit");
            $finish;
        end
    end

    initial begin : stim_proc
        t_exec_req   r;
        logic [31:0] a;
        int          k;

        // directed: extremes, every class and the corner cases
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_ADD, 1'b0, 32'hFFFF_FFFF, 32'h1, 32'h0,
                32'h100, 5'd31, 1'b0);
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_ADD, 1'b1, 32'h0, 32'h1, 32'h0,
                32'h104, 5'd1, 1'b0);
        add_req(rvex_pkg::REQ_OPIMM, rvex_pkg::F3_ADD, 1'b1, 32'h10, 32'h0, 32'hFFFF_FFFF,
                32'h108, 5'd2, 1'b0);
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_SLL, 1'b0, 32'h1, 32'h25, 32'h0,
                32'h10C, 5'd3, 1'b0);
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_SR, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                32'h0, 5'd4, 1'b0);
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_SR, 1'b0, 32'h8000_0000, 32'd31, 32'h0,
                32'h0, 5'd5, 1'b0);
        add_req(rvex_pkg::REQ_OPIMM, rvex_pkg::F3_SR, 1'b1, 32'hF000_0000, 32'h0,
                32'h0000_041F, 32'h0, 5'd6, 1'b0);
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_SLT, 1'b0, 32'hFFFF_FFFF, 32'h1, 32'h0,
                32'h0, 5'd7, 1'b0);
        add_req(rvex_pkg::REQ_OPIMM, rvex_pkg::F3_SLTU, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h1,
                32'h0, 5'd8, 1'b0);
        add_req(rvex_pkg::REQ_OPIMM, rvex_pkg::F3_XOR, 1'b0, 32'hA5A5_A5A5, 32'h0,
                32'hFFFF_FFFF, 32'h0, 5'd9, 1'b0);
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_OR, 1'b1, 32'hF0F0_0000, 32'h0000_0F0F, 32'h0,
                32'h0, 5'd10, 1'b0);
        add_req(rvex_pkg::REQ_OP, rvex_pkg::F3_AND, 1'b0, 32'hFFFF_0000, 32'h00FF_FF00,
                32'h0, 32'h0, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_BRANCH, rvex_pkg::F3_BEQ, 1'b0, 32'h1234, 32'h1234,
                32'hFFFF_FFF0, 32'h10, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_BRANCH, rvex_pkg::F3_BNE, 1'b0, 32'h5, 32'h5, 32'h20,
                32'h200, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_BRANCH, rvex_pkg::F3_BLT, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8, 32'h300, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_BRANCH, rvex_pkg::F3_BGE, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8, 32'h300, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_BRANCH, rvex_pkg::F3_BLTU, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8, 32'h300, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_BRANCH, rvex_pkg::F3_BGEU, 1'b0, 32'h0, 32'hFFFF_FFFF,
                32'h8, 32'h300, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_BRANCH, 3'b010, 1'b0, 32'h1, 32'h1, 32'h8, 32'h300, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_JAL, 3'b000, 1'b0, 32'h0, 32'h0, 32'h10, 32'hFFFF_FFFC, 5'd1,
                1'b0);
        add_req(rvex_pkg::REQ_JALR, 3'b000, 1'b0, 32'h0000_1001, 32'h0, 32'h2, 32'h40, 5'd31,
                1'b0);
        add_req(rvex_pkg::REQ_LUI, 3'b111, 1'b1, 32'h0, 32'h0, 32'hFFFF_F000, 32'h0, 5'd12,
                1'b0);
        add_req(rvex_pkg::REQ_AUIPC, 3'b000, 1'b0, 32'h0, 32'h0, 32'h8000_0000,
                32'h8000_0004, 5'd13, 1'b0);
        add_req(rvex_pkg::REQ_STORE, rvex_pkg::F3_MB, 1'b0, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
                32'h1, 32'h0, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_STORE, 3'b011, 1'b0, 32'h100, 32'h55, 32'h4, 32'h0, 5'd0, 1'b0);
        add_req(rvex_pkg::REQ_LOAD, rvex_pkg::F3_MHU, 1'b0, 32'h1000, 32'h0, 32'hFFFF_FFFE,
                32'h0, 5'd14, 1'b0);
        add_req(rvex_pkg::REQ_LOAD, 3'b110, 1'b0, 32'h1000, 32'h0, 32'h4, 32'h0, 5'd15, 1'b0);
        add_req(rvex_pkg::REQ_HALT, 3'b000, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0, 1'b0);
        add_req(4'd15, 3'b111, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 5'd31, 1'b0);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 9) == 0)
                r.req_type = 4'($urandom_range(10, 15));
            else
                r.req_type = 4'($urandom_range(0, 9));
            r.funct3  = 3'($urandom_range(0, 7));
            r.alt_bit = 1'($urandom_range(0, 1));
            r.src1    = rand_operand();
            r.src2    = rand_operand();
            r.imm     = rand_imm();
            a         = $urandom;
            r.pc      = ($urandom_range(0, 3) == 0) ? a : {a[31:2], 2'b00};
            r.rd      = 5'($urandom_range(0, 31));
            // equal operands make eq/ne and ge/lt edges common
            if (r.req_type == rvex_pkg::REQ_BRANCH && $urandom_range(0, 3) == 0)
                r.src2 = r.src1;
            r.drain_first = (k == 0 || k == 250 || k == 500);
            pending_reqs.push_back(r);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || exec_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (n_errors == 0 && exec_results.size() == 0) begin
            $display("PASS rv32i_execute_unit");
        end else begin
            $display("FAIL rv32i_execute_unit");
        end
        $finish;
    end

endmodule
